[rtl/sps_pkg.sv]
`default_nettype none
package sps_pkg;

   localparam int NQ = 16;
   localparam int NW = 8;
   localparam int QW = $clog2(NQ);
   localparam int WW = $clog2(NW);
   localparam int EVQ_DEPTH = 2;
   localparam int RSPQ_DEPTH = 4;
   localparam int RSP_MAX = 3;

   typedef enum logic [2:0] {
      EV_NEW    = 3'd0,
      EV_JOIN   = 3'd1,
      EV_LEAVE  = 3'd2,
      EV_END    = 3'd3,
      EV_CLIENT = 3'd4,
      EV_PCRET  = 3'd5,
      EV_TICK   = 3'd6,
      EV_NOP    = 3'd7
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [7:0]  worker_id;
      logic [3:0]  query_slot;
      logic [7:0]  priority_req;
      logic [30:0] pc;
      logic [3:0]  exit_reason;
   } ev_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  out_worker;
      logic [3:0]  out_slot;
      logic [7:0]  out_priority;
      logic [30:0] out_pc;
      logic [3:0]  out_reason;
      logic        last;
   } rsp_type;

   localparam logic [2:0] CMD_ACCEPT   = 3'd0;
   localparam logic [2:0] CMD_DISPATCH = 3'd1;
   localparam logic [2:0] CMD_PREEMPT  = 3'd2;
   localparam logic [2:0] CMD_END      = 3'd3;
   localparam logic [2:0] CMD_REJECT   = 3'd4;

   localparam logic [1:0] Q_FREE    = 2'd0;
   localparam logic [1:0] Q_READY   = 2'd1;
   localparam logic [1:0] Q_RUN     = 2'd2;
   localparam logic [1:0] Q_PREEMPT = 2'd3;

   localparam logic [1:0] VB_ABSENT = 2'b00;
   localparam logic [1:0] VB_IDLE   = 2'b01;
   localparam logic [1:0] VB_BUSY   = 2'b11;

   localparam logic [3:0]  REASON_DISCONNECT = 4'd15;
   localparam logic [15:0] AGING_RESET       = 16'd1000;
   localparam logic        CSR_MODE          = 1'b0;
   localparam logic        CSR_PERIOD        = 1'b1;

endpackage
`default_nettype wire

[rtl/sps_front.sv]
`default_nettype none
module sps_front import sps_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [2:0]  req_type,
   input  wire logic [7:0]  req_worker_id,
   input  wire logic [3:0]  req_query_slot,
   input  wire logic [7:0]  req_priority_req,
   input  wire logic [30:0] req_pc,
   input  wire logic [3:0]  req_exit_reason,
   output logic             ev_valid,
   output ev_type           ev_data,
   input  wire logic        ev_pop
);
   localparam int PW = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
   localparam int CW = $clog2(EVQ_DEPTH + 1);

   ev_type          mem_ff [EVQ_DEPTH];
   logic [PW-1:0]   wptr_ff, rptr_ff;
   logic [CW-1:0]   cnt_ff;
   ev_type          ev_in;
   logic            wr, rd;

   always_comb begin
      ev_in.kind         = ev_kind_type'(req_type);
      ev_in.worker_id    = req_worker_id;
      ev_in.query_slot   = req_query_slot;
      ev_in.priority_req = req_priority_req;
      ev_in.pc           = req_pc;
      ev_in.exit_reason  = req_exit_reason;
   end

   assign full     = (cnt_ff == CW'(EVQ_DEPTH));
   assign ev_valid = (cnt_ff != '0);
   assign ev_data  = mem_ff[rptr_ff];
   assign wr       = push && !full;
   assign rd       = ev_pop && ev_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (wr) begin
            mem_ff[wptr_ff] <= ev_in;
            wptr_ff <= (wptr_ff == PW'(EVQ_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (rd) begin
            rptr_ff <= (rptr_ff == PW'(EVQ_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
         if (wr && !rd) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (rd && !wr) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[rtl/sps_rsp_fifo.sv]
`default_nettype none
module sps_rsp_fifo import sps_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr,
   input  rsp_type   wr_data,
   output logic      room,
   output logic      empty,
   input  wire logic pop,
   output rsp_type   rd_data
);
   localparam int PW = $clog2(RSPQ_DEPTH);
   localparam int CW = $clog2(RSPQ_DEPTH + 1);

   rsp_type        mem_ff [RSPQ_DEPTH];
   logic [PW-1:0]  wptr_ff, rptr_ff;
   logic [CW-1:0]  cnt_ff;
   logic           rd;

   assign empty   = (cnt_ff == '0);
   assign room    = (cnt_ff <= CW'(RSPQ_DEPTH - RSP_MAX));
   assign rd_data = mem_ff[rptr_ff];
   assign rd      = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (wr) begin
            mem_ff[wptr_ff] <= wr_data;
            wptr_ff <= (wptr_ff == PW'(RSPQ_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (rd) begin
            rptr_ff <= (rptr_ff == PW'(RSPQ_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
         if (wr && !rd) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (rd && !wr) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr |-> (cnt_ff != CW'(RSPQ_DEPTH)) || rd)
      else $error("result queue overflow");

endmodule
`default_nettype wire

[rtl/sps_engine.sv]
`default_nettype none
module sps_engine import sps_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        ev_valid,
   input  ev_type           ev_data,
   output logic             ev_pop,
   input  wire logic        rsp_room,
   output logic             rsp_push,
   output rsp_type          rsp_data
);
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EXEC  = 7'b0000010,
      S_QSCAN = 7'b0000100,
      S_WPICK = 7'b0001000,
      S_VSCAN = 7'b0010000,
      S_VDEC  = 7'b0100000,
      S_DONE  = 7'b1000000
   } st_type;

   st_type          st_ff;
   ev_type          ev_ff;
   logic            mode_ff;
   logic [15:0]     period_ff;
   logic [1:0]      qstate_ff [NQ];
   logic [15:0]     age_ff    [NQ];
   logic [7:0]      prio_ff   [NQ];
   logic [30:0]     pc_ff     [NQ];
   logic [15:0]     order_ff  [NQ];
   logic [1:0]      vb_ff     [NW];
   logic [7:0]      ident_ff  [NW];
   logic [QW-1:0]   wq_ff     [NW];
   logic [15:0]     ocnt_ff;
   logic [QW-1:0]   qidx_ff;
   logic [WW-1:0]   widx_ff;
   logic            best_v_ff;
   logic [QW-1:0]   best_ff;
   logic [7:0]      bprio_ff;
   logic [15:0]     bwait_ff;
   logic            vic_v_ff;
   logic [WW-1:0]   vic_w_ff;
   logic [QW-1:0]   vic_q_ff;
   logic [7:0]      vprio_ff;
   logic            pend_v_ff;
   rsp_type         pend_ff;

   logic            free_found, fw_found, join_found, idle_found, woq_found;
   logic [QW-1:0]   free_idx;
   logic [WW-1:0]   fw_idx, join_idx, idle_idx, woq_idx;
   logic [QW-1:0]   fw_q, cl_q, vw_q;
   logic [1:0]      fw_qst, cl_st, sq_state;
   logic            end_hit, pcret_hit, join_do, take, vtake;
   logic [7:0]      sq_prio;
   logic [15:0]     sq_wait, period_eff;
   logic [16:0]     age_inc [NQ];
   logic            age_wrap [NQ];
   logic            emit_en;
   rsp_type         emit_data;

   // table lookups
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NQ - 1; i >= 0; i--) begin
         if (qstate_ff[i] == Q_FREE) begin
            free_found = 1'b1;
            free_idx   = QW'(i);
         end
      end
      fw_found   = 1'b0;
      fw_idx     = '0;
      join_found = 1'b0;
      join_idx   = '0;
      idle_found = 1'b0;
      idle_idx   = '0;
      woq_found  = 1'b0;
      woq_idx    = '0;
      for (int i = NW - 1; i >= 0; i--) begin
         if (vb_ff[i][0] && ident_ff[i] == ev_ff.worker_id) begin
            fw_found = 1'b1;
            fw_idx   = WW'(i);
         end
         if (!vb_ff[i][0]) begin
            join_found = 1'b1;
            join_idx   = WW'(i);
         end
         if (vb_ff[i] == VB_IDLE) begin
            idle_found = 1'b1;
            idle_idx   = WW'(i);
         end
         if (vb_ff[i] == VB_BUSY && wq_ff[i] == cl_q) begin
            woq_found = 1'b1;
            woq_idx   = WW'(i);
         end
      end
   end

   assign cl_q      = ev_ff.query_slot;
   assign cl_st     = qstate_ff[cl_q];
   assign fw_q      = wq_ff[fw_idx];
   assign fw_qst    = qstate_ff[fw_q];
   assign end_hit   = fw_found && vb_ff[fw_idx][1] && (fw_qst == Q_RUN || fw_qst == Q_PREEMPT);
   assign pcret_hit = fw_found && vb_ff[fw_idx] == VB_BUSY && fw_q == cl_q
                      && (cl_st == Q_RUN || cl_st == Q_PREEMPT);
   assign join_do   = !fw_found && join_found;
   assign period_eff = (period_ff == '0) ? 16'd1 : period_ff;

   always_comb begin
      for (int i = 0; i < NQ; i++) begin
         age_inc[i]  = {1'b0, age_ff[i]} + 17'd1;
         age_wrap[i] = (age_inc[i] >= {1'b0, period_eff});
      end
   end

   // query scan and victim scan
   assign sq_state = qstate_ff[qidx_ff];
   assign sq_prio  = prio_ff[qidx_ff];
   assign sq_wait  = ocnt_ff - order_ff[qidx_ff];
   assign take = (sq_state == Q_READY) && (!best_v_ff ||
                 (mode_ff ? (sq_prio < bprio_ff || (sq_prio == bprio_ff && sq_wait > bwait_ff))
                          : (sq_wait > bwait_ff)));
   assign vw_q  = wq_ff[widx_ff];
   assign vtake = (vb_ff[widx_ff] == VB_BUSY) && (qstate_ff[vw_q] == Q_RUN)
                  && (!vic_v_ff || prio_ff[vw_q] > vprio_ff);

   always_comb begin
      emit_en   = 1'b0;
      emit_data = '0;
      unique case (st_ff)
         S_EXEC: begin
            case (ev_ff.kind)
               EV_NEW: begin
                  emit_en = 1'b1;
                  emit_data.out_priority = ev_ff.priority_req;
                  if (free_found) begin
                     emit_data.cmd      = CMD_ACCEPT;
                     emit_data.out_slot = free_idx;
                  end else begin
                     emit_data.cmd = CMD_REJECT;
                  end
               end
               EV_LEAVE, EV_END: begin
                  if (end_hit) begin
                     emit_en = 1'b1;
                     emit_data.cmd          = CMD_END;
                     emit_data.out_slot     = fw_q;
                     emit_data.out_priority = prio_ff[fw_q];
                     emit_data.out_reason   = (ev_ff.kind == EV_LEAVE) ? REASON_DISCONNECT
                                                                       : ev_ff.exit_reason;
                  end
               end
               EV_CLIENT: begin
                  if (cl_st == Q_RUN && woq_found) begin
                     emit_en = 1'b1;
                     emit_data.cmd          = CMD_PREEMPT;
                     emit_data.out_worker   = ident_ff[woq_idx];
                     emit_data.out_slot     = cl_q;
                     emit_data.out_priority = prio_ff[cl_q];
                  end
               end
               default: ;
            endcase
         end
         S_WPICK: begin
            if (best_v_ff && idle_found) begin
               emit_en = 1'b1;
               emit_data.cmd          = CMD_DISPATCH;
               emit_data.out_worker   = ident_ff[idle_idx];
               emit_data.out_slot     = best_ff;
               emit_data.out_priority = bprio_ff;
               emit_data.out_pc       = pc_ff[best_ff];
            end
         end
         S_VDEC: begin
            if (vic_v_ff && vprio_ff > bprio_ff) begin
               emit_en = 1'b1;
               emit_data.cmd          = CMD_PREEMPT;
               emit_data.out_worker   = ident_ff[vic_w_ff];
               emit_data.out_slot     = vic_q_ff;
               emit_data.out_priority = vprio_ff;
            end
         end
         default: ;
      endcase
   end

   assign ev_pop   = (st_ff == S_IDLE) && ev_valid && rsp_room;
   assign rsp_push = pend_v_ff && (emit_en || st_ff == S_DONE);

   always_comb begin
      rsp_data      = pend_ff;
      rsp_data.last = (st_ff == S_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         mode_ff   <= 1'b0;
         period_ff <= AGING_RESET;
         ocnt_ff   <= '0;
         pend_v_ff <= 1'b0;
         best_v_ff <= 1'b0;
         vic_v_ff  <= 1'b0;
         qidx_ff   <= '0;
         widx_ff   <= '0;
         for (int i = 0; i < NQ; i++) begin
            qstate_ff[i] <= Q_FREE;
            age_ff[i]    <= '0;
         end
         for (int i = 0; i < NW; i++) begin
            vb_ff[i] <= VB_ABSENT;
         end
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_MODE) begin
               mode_ff <= csr_wdata[0];
            end else begin
               period_ff <= csr_wdata;
            end
         end
         // the previous result goes out as this one takes its place
         if (emit_en) begin
            pend_v_ff <= 1'b1;
            pend_ff   <= emit_data;
         end
         unique case (st_ff)
            S_IDLE: begin
               if (ev_valid && rsp_room) begin
                  ev_ff <= ev_data;
                  st_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               qidx_ff   <= '0;
               best_v_ff <= 1'b0;
               st_ff     <= (ev_ff.kind == EV_NOP) ? S_DONE : S_QSCAN;
               case (ev_ff.kind)
                  EV_NEW: begin
                     if (free_found) begin
                        prio_ff[free_idx]   <= ev_ff.priority_req;
                        pc_ff[free_idx]     <= '0;
                        qstate_ff[free_idx] <= Q_READY;
                        order_ff[free_idx]  <= ocnt_ff;
                        age_ff[free_idx]    <= '0;
                        ocnt_ff             <= ocnt_ff + 16'd1;
                     end
                  end
                  EV_JOIN: begin
                     if (join_do) begin
                        vb_ff[join_idx]    <= VB_IDLE;
                        ident_ff[join_idx] <= ev_ff.worker_id;
                        wq_ff[join_idx]    <= '0;
                     end
                  end
                  EV_LEAVE, EV_END: begin
                     if (fw_found) begin
                        if (end_hit) begin
                           qstate_ff[fw_q] <= Q_FREE;
                        end
                        vb_ff[fw_idx] <= (ev_ff.kind == EV_LEAVE) ? VB_ABSENT : VB_IDLE;
                     end
                  end
                  EV_CLIENT: begin
                     if (cl_st == Q_READY) begin
                        qstate_ff[cl_q] <= Q_FREE;
                     end else if (cl_st == Q_RUN || cl_st == Q_PREEMPT) begin
                        if (woq_found) begin
                           vb_ff[woq_idx] <= VB_IDLE;
                        end
                        qstate_ff[cl_q] <= Q_FREE;
                     end
                  end
                  EV_PCRET: begin
                     if (pcret_hit) begin
                        pc_ff[cl_q]     <= ev_ff.pc;
                        qstate_ff[cl_q] <= Q_READY;
                        order_ff[cl_q]  <= ocnt_ff;
                        age_ff[cl_q]    <= '0;
                        ocnt_ff         <= ocnt_ff + 16'd1;
                        vb_ff[fw_idx]   <= VB_IDLE;
                     end
                  end
                  EV_TICK: begin
                     if (mode_ff) begin
                        for (int i = 0; i < NQ; i++) begin
                           if (qstate_ff[i] == Q_READY) begin
                              if (age_wrap[i]) begin
                                 age_ff[i] <= '0;
                                 if (prio_ff[i] != '0) begin
                                    prio_ff[i] <= prio_ff[i] - 8'd1;
                                 end
                              end else begin
                                 age_ff[i] <= age_inc[i][15:0];
                              end
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
            S_QSCAN: begin
               if (take) begin
                  best_v_ff <= 1'b1;
                  best_ff   <= qidx_ff;
                  bprio_ff  <= sq_prio;
                  bwait_ff  <= sq_wait;
               end
               if (qidx_ff == QW'(NQ - 1)) begin
                  st_ff <= S_WPICK;
               end
               qidx_ff <= qidx_ff + 1'b1;
            end
            S_WPICK: begin
               if (!best_v_ff) begin
                  st_ff <= S_DONE;
               end else if (idle_found) begin
                  qstate_ff[best_ff] <= Q_RUN;
                  vb_ff[idle_idx]    <= VB_BUSY;
                  wq_ff[idle_idx]    <= best_ff;
                  st_ff              <= S_DONE;
               end else if (!mode_ff) begin
                  st_ff <= S_DONE;
               end else begin
                  widx_ff  <= '0;
                  vic_v_ff <= 1'b0;
                  st_ff    <= S_VSCAN;
               end
            end
            S_VSCAN: begin
               if (vtake) begin
                  vic_v_ff <= 1'b1;
                  vic_w_ff <= widx_ff;
                  vic_q_ff <= vw_q;
                  vprio_ff <= prio_ff[vw_q];
               end
               if (widx_ff == WW'(NW - 1)) begin
                  st_ff <= S_VDEC;
               end
               widx_ff <= widx_ff + 1'b1;
            end
            S_VDEC: begin
               if (vic_v_ff && vprio_ff > bprio_ff) begin
                  qstate_ff[vic_q_ff] <= Q_PREEMPT;
               end
               st_ff <= S_DONE;
            end
            S_DONE: begin
               pend_v_ff <= 1'b0;
               st_ff     <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_DONE |=> st_ff == S_IDLE)
      else $error("sequencer did not return to idle");

   a_flushed: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_IDLE |-> !pend_v_ff)
      else $error("result left behind between events");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_QSCAN && qidx_ff == QW'(NQ - 1)) |=> st_ff == S_WPICK)
      else $error("query scan did not end");

endmodule
`default_nettype wire

[rtl/priority_scheduler_aging_preempt_core.sv]
`default_nettype none
// Preemptive priority scheduler with aging. Events enter through a two-deep
// queue (push/full) and results leave through a four-deep queue (empty/pop);
// each event gives at most two results, the last one flagged. A sequencer
// handles one event at a time: it takes the event from the event queue,
// applies it, scans the sixteen-entry query table entry by entry, picks a
// worker and hands over the last result; in priority mode with no worker
// free, it also scans the eight worker entries for a victim and decides on
// a preemption first. An unused event code skips the scans and the pick. An
// event starts only when the result queue has room for three results.
module priority_scheduler_aging_preempt_core import sps_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [2:0]  req_type,
   input  wire logic [7:0]  req_worker_id,
   input  wire logic [3:0]  req_query_slot,
   input  wire logic [7:0]  req_priority_req,
   input  wire logic [30:0] req_pc,
   input  wire logic [3:0]  req_exit_reason,
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_cmd,
   output logic [7:0]       rsp_out_worker,
   output logic [3:0]       rsp_out_slot,
   output logic [7:0]       rsp_out_priority,
   output logic [30:0]      rsp_out_pc,
   output logic [3:0]       rsp_out_reason,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   logic    ev_valid, ev_pop, rsp_room, rsp_push;
   ev_type  ev_data;
   rsp_type rsp_data, rsp_head;

   sps_front u_front (
      .clock, .reset, .push, .full,
      .req_type, .req_worker_id, .req_query_slot, .req_priority_req,
      .req_pc, .req_exit_reason,
      .ev_valid, .ev_data, .ev_pop
   );

   sps_engine u_engine (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wdata,
      .ev_valid, .ev_data, .ev_pop,
      .rsp_room, .rsp_push, .rsp_data
   );

   sps_rsp_fifo u_rsp_fifo (
      .clock, .reset,
      .wr(rsp_push), .wr_data(rsp_data), .room(rsp_room),
      .empty, .pop, .rd_data(rsp_head)
   );

   assign rsp_cmd          = rsp_head.cmd;
   assign rsp_out_worker   = rsp_head.out_worker;
   assign rsp_out_slot     = rsp_head.out_slot;
   assign rsp_out_priority = rsp_head.out_priority;
   assign rsp_out_pc       = rsp_head.out_pc;
   assign rsp_out_reason   = rsp_head.out_reason;
   assign rsp_last         = rsp_head.last;

endmodule
`default_nettype wire

[tb/priority_scheduler_aging_preempt_core_tb.sv]
`default_nettype none
module priority_scheduler_aging_preempt_core_tb import sps_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_type = EV_NOP;
   logic [7:0]  req_worker_id = '0;
   logic [3:0]  req_query_slot = '0;
   logic [7:0]  req_priority_req = '0;
   logic [30:0] req_pc = '0;
   logic [3:0]  req_exit_reason = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [2:0]  rsp_cmd;
   logic [7:0]  rsp_out_worker;
   logic [3:0]  rsp_out_slot;
   logic [7:0]  rsp_out_priority;
   logic [30:0] rsp_out_pc;
   logic [3:0]  rsp_out_reason;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_MODE;
   logic [15:0] csr_wdata = '0;

   priority_scheduler_aging_preempt_core u_top (.*);

   initial forever #5 clock = ~clock;

   // scheduler mirror
   logic [1:0]  q_state [NQ];
   logic [7:0]  q_prio [NQ];
   logic [30:0] q_pc [NQ];
   logic [15:0] q_order [NQ];
   logic [15:0] q_age [NQ];
   logic [1:0]  w_vb [NW];
   logic [7:0]  w_ident [NW];
   logic [3:0]  w_query [NW];
   logic [15:0] order_cnt;
   logic        mode_prio;
   logic [15:0] period;

   rsp_type pending_cmds [$];
   rsp_type batch [$];
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold = 0;
   int mismatches = 0;
   int n_events = 0;
   int n_results = 0;
   int n_preempts = 0;
   int n_rejects = 0;

   localparam logic [7:0] ID_POOL [12] = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4,
                                          8'd5, 8'd6, 8'd7, 8'd128, 8'd170, 8'd85};

   function automatic void add_cmd(logic [2:0] c, logic [7:0] w, logic [3:0] s,
                                   logic [7:0] p, logic [30:0] pcv, logic [3:0] r);
      rsp_type x;
      x = '{c, w, s, p, pcv, r, 1'b0};
      batch.push_back(x);
   endfunction

   function automatic bit waits_longer(int a, int b);
      logic [15:0] wa, wb;
      wa = order_cnt - q_order[a];
      wb = order_cnt - q_order[b];
      return wa > wb;
   endfunction

   function automatic void mark_ready(int q);
      q_state[q] = Q_READY;
      q_order[q] = order_cnt;
      order_cnt = order_cnt + 16'd1;
      q_age[q] = '0;
   endfunction

   function automatic int lookup_worker(logic [7:0] id);
      for (int i = 0; i < NW; i++)
         if (w_vb[i][0] && w_ident[i] == id) return i;
      return -1;
   endfunction

   function automatic void schedule();
      int pick, w, v;
      pick = -1;
      w = -1;
      for (int i = 0; i < NQ; i++) begin
         if (q_state[i] != Q_READY) continue;
         if (pick < 0) pick = i;
         else if (mode_prio) begin
            if (q_prio[i] < q_prio[pick] ||
                (q_prio[i] == q_prio[pick] && waits_longer(i, pick))) pick = i;
         end else if (waits_longer(i, pick)) pick = i;
      end
      if (pick < 0) return;
      for (int i = 0; i < NW; i++)
         if (w_vb[i] == VB_IDLE) begin
            w = i;
            break;
         end
      if (w >= 0) begin
         q_state[pick] = Q_RUN;
         w_vb[w] = VB_BUSY;
         w_query[w] = pick[3:0];
         add_cmd(CMD_DISPATCH, w_ident[w], pick[3:0], q_prio[pick], q_pc[pick], 4'd0);
         return;
      end
      if (!mode_prio) return;
      for (int i = 0; i < NW; i++) begin
         if (w_vb[i] != VB_BUSY || q_state[w_query[i]] != Q_RUN) continue;
         if (w < 0 || q_prio[w_query[i]] > q_prio[w_query[w]]) w = i;
      end
      if (w >= 0 && q_prio[w_query[w]] > q_prio[pick]) begin
         v = w_query[w];
         q_state[v] = Q_PREEMPT;
         add_cmd(CMD_PREEMPT, w_ident[w], v[3:0], q_prio[v], '0, 4'd0);
      end
   endfunction

   function automatic void predict_event(ev_kind_type k, logic [7:0] id, logic [3:0] s,
                                         logic [7:0] p, logic [30:0] pcv, logic [3:0] r);
      int i, w, q;
      batch.delete();
      case (k)
         EV_NEW: begin
            for (i = 0; i < NQ; i++)
               if (q_state[i] == Q_FREE) break;
            if (i >= NQ) add_cmd(CMD_REJECT, '0, '0, p, '0, 4'd0);
            else begin
               q_prio[i] = p;
               q_pc[i] = '0;
               mark_ready(i);
               add_cmd(CMD_ACCEPT, '0, i[3:0], p, '0, 4'd0);
            end
         end
         EV_JOIN: begin
            if (lookup_worker(id) < 0)
               for (i = 0; i < NW; i++)
                  if (!w_vb[i][0]) begin
                     w_vb[i] = VB_IDLE;
                     w_ident[i] = id;
                     w_query[i] = '0;
                     break;
                  end
         end
         EV_LEAVE, EV_END: begin
            w = lookup_worker(id);
            if (w >= 0) begin
               if (w_vb[w][1]) begin
                  q = w_query[w];
                  if (q_state[q] == Q_RUN || q_state[q] == Q_PREEMPT) begin
                     q_state[q] = Q_FREE;
                     add_cmd(CMD_END, '0, q[3:0], q_prio[q], '0,
                             k == EV_LEAVE ? REASON_DISCONNECT : r);
                  end
               end
               w_vb[w] = (k == EV_LEAVE) ? VB_ABSENT : VB_IDLE;
            end
         end
         EV_CLIENT: begin
            if (q_state[s] == Q_READY) q_state[s] = Q_FREE;
            else if (q_state[s] == Q_RUN || q_state[s] == Q_PREEMPT) begin
               w = -1;
               for (i = 0; i < NW; i++)
                  if (w_vb[i] == VB_BUSY && w_query[i] == s) begin
                     w = i;
                     break;
                  end
               if (w >= 0) begin
                  if (q_state[s] == Q_RUN)
                     add_cmd(CMD_PREEMPT, w_ident[w], s, q_prio[s], '0, 4'd0);
                  w_vb[w] = VB_IDLE;
               end
               q_state[s] = Q_FREE;
            end
         end
         EV_PCRET: begin
            w = lookup_worker(id);
            if (w >= 0 && w_vb[w] == VB_BUSY && w_query[w] == s &&
                (q_state[s] == Q_RUN || q_state[s] == Q_PREEMPT)) begin
               q_pc[s] = pcv;
               mark_ready(s);
               w_vb[w] = VB_IDLE;
            end
         end
         EV_TICK: begin
            if (mode_prio)
               for (i = 0; i < NQ; i++) begin
                  if (q_state[i] != Q_READY) continue;
                  if (32'(q_age[i]) + 1 >= ((period == 0) ? 32'd1 : 32'(period))) begin
                     q_age[i] = '0;
                     if (q_prio[i] > 0) q_prio[i] = q_prio[i] - 8'd1;
                  end else q_age[i] = q_age[i] + 16'd1;
               end
         end
         default: return;
      endcase
      schedule();
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[j]) begin
         if (batch[j].cmd == CMD_PREEMPT) n_preempts++;
         if (batch[j].cmd == CMD_REJECT) n_rejects++;
         pending_cmds.push_back(batch[j]);
      end
   endfunction

   // one transfer on the event side; push is left high when the task returns
   task automatic send_ev(ev_kind_type k, logic [7:0] id, logic [3:0] s,
                          logic [7:0] p, logic [30:0] pcv, logic [3:0] r);
      if ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      push <= 1'b1;
      req_type <= k;
      req_worker_id <= id;
      req_query_slot <= s;
      req_priority_req <= p;
      req_pc <= pcv;
      req_exit_reason <= r;
      do @(posedge clock); while (full);
      predict_event(k, id, s, p, pcv, r);
      n_events++;
   endtask

   task automatic park();
      push <= 1'b0;
      wait (pending_cmds.size() == 0);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      park();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_MODE) mode_prio = val[0];
      else period = val;
   endtask

   task automatic send_random();
      int roll, busy [$];
      logic [7:0] id;
      logic [3:0] s;
      roll = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? 8'($urandom) : ID_POOL[$urandom_range(11)];
      s = 4'($urandom);
      busy.delete();
      for (int i = 0; i < NW; i++) if (w_vb[i] == VB_BUSY) busy.push_back(i);
      if (roll < 24) send_ev(EV_NEW, id, s, 8'($urandom), 31'($urandom), 4'($urandom));
      else if (roll < 34) send_ev(EV_JOIN, id, s, 8'($urandom), 31'($urandom), 4'($urandom));
      else if (roll < 40) send_ev(EV_LEAVE, id, s, 8'($urandom), 31'($urandom), 4'($urandom));
      else if (roll < 54) begin
         if (busy.size() > 0 && $urandom_range(3) != 0) id = w_ident[busy[$urandom_range(busy.size() - 1)]];
         send_ev(EV_END, id, s, 8'($urandom), 31'($urandom), 4'($urandom));
      end else if (roll < 61) send_ev(EV_CLIENT, id, s, 8'($urandom), 31'($urandom), 4'($urandom));
      else if (roll < 82) begin
         // mostly well-formed returns from a worker that holds the slot
         if (busy.size() > 0 && $urandom_range(4) != 0) begin
            roll = busy[$urandom_range(busy.size() - 1)];
            id = w_ident[roll];
            s = w_query[roll];
         end
         send_ev(EV_PCRET, id, s, 8'($urandom), 31'($urandom), 4'($urandom));
      end else if (roll < 98) send_ev(EV_TICK, id, s, 8'($urandom), 31'($urandom), 4'($urandom));
      else send_ev(EV_NOP, id, s, 8'($urandom), 31'($urandom), 4'($urandom));
   endtask

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         n_results++;
         if (pending_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result cmd=%0d slot=%0d", rsp_cmd, rsp_out_slot);
         end else begin
            if (pending_cmds[0] != {rsp_cmd, rsp_out_worker, rsp_out_slot, rsp_out_priority,
                                    rsp_out_pc, rsp_out_reason, rsp_last}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: exp cmd=%0d w=%0d s=%0d p=%0d pc=%h r=%0d l=%0d, got cmd=%0d w=%0d s=%0d p=%0d pc=%h r=%0d l=%0d",
                     pending_cmds[0].cmd, pending_cmds[0].out_worker, pending_cmds[0].out_slot,
                     pending_cmds[0].out_priority, pending_cmds[0].out_pc,
                     pending_cmds[0].out_reason, pending_cmds[0].last,
                     rsp_cmd, rsp_out_worker, rsp_out_slot, rsp_out_priority, rsp_out_pc,
                     rsp_out_reason, rsp_last);
            end
            void'(pending_cmds.pop_front());
         end
      end
      if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         pop <= 1'b0;
      end else pop <= ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic test_directed();
      send_ev(EV_NEW, 8'd0, 4'd0, 8'd255, 31'h7fffffff, 4'd15);
      send_ev(EV_JOIN, 8'd0, 4'd0, 8'd0, '0, 4'd0);
      send_ev(EV_JOIN, 8'd0, 4'd0, 8'd0, '0, 4'd0);
      send_ev(EV_JOIN, 8'd255, 4'd15, 8'd255, 31'h7fffffff, 4'd15);
      send_ev(EV_NEW, 8'd255, 4'd15, 8'd0, '0, 4'd0);
      send_ev(EV_LEAVE, 8'd77, 4'd0, 8'd0, '0, 4'd0);
      send_ev(EV_END, 8'd0, 4'd0, 8'd0, '0, 4'd0);
      send_ev(EV_END, 8'd0, 4'd0, 8'd0, '0, 4'd9);
      send_ev(EV_PCRET, 8'd255, 4'd5, 8'd0, 31'h7fffffff, 4'd0);
      send_ev(EV_PCRET, 8'd255, 4'd1, 8'd0, 31'h7fffffff, 4'd0);
      send_ev(EV_CLIENT, 8'd0, 4'd15, 8'd0, '0, 4'd0);
      send_ev(EV_NEW, 8'd0, 4'd0, 8'd200, '0, 4'd0);
      send_ev(EV_NOP, 8'd255, 4'd15, 8'd255, 31'h7fffffff, 4'd15);
      send_ev(EV_TICK, 8'd0, 4'd0, 8'd0, '0, 4'd0);
      write_csr(CSR_PERIOD, 16'd1);
      write_csr(CSR_MODE, 16'd1);
      send_ev(EV_NEW, 8'd0, 4'd0, 8'd250, '0, 4'd0);
      send_ev(EV_NEW, 8'd0, 4'd0, 8'd3, '0, 4'd0);
      send_ev(EV_PCRET, 8'd0, 4'd0, 8'd0, 31'h2aaaaaaa, 4'd0);
      send_ev(EV_TICK, 8'd0, 4'd0, 8'd0, '0, 4'd0);
      send_ev(EV_CLIENT, 8'd0, 4'd1, 8'd0, '0, 4'd0);
      send_ev(EV_CLIENT, 8'd0, 4'd2, 8'd0, '0, 4'd0);
      send_ev(EV_LEAVE, 8'd255, 4'd0, 8'd0, '0, 4'd0);
      send_ev(EV_END, 8'd0, 4'd0, 8'd0, '0, 4'd15);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < 18; i++)
         send_ev(EV_NEW, 8'($urandom), 4'($urandom), 8'($urandom), 31'($urandom), 4'($urandom));
   endtask

   task automatic test_random(int count);
      repeat (count) send_random();
   endtask

   task automatic test_backpressure();
      park();
      tx_idle_pct = 0;
      rx_hold = 500;
      repeat (16) send_random();
   endtask

   initial begin
      foreach (q_state[i]) begin
         q_state[i] = Q_FREE; q_prio[i] = '0; q_pc[i] = '0; q_order[i] = '0; q_age[i] = '0;
      end
      foreach (w_vb[i]) begin
         w_vb[i] = VB_ABSENT; w_ident[i] = '0; w_query[i] = '0;
      end
      order_cnt = '0;
      mode_prio = 1'b0;
      period = AGING_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      write_csr(CSR_PERIOD, 16'd3);
      tx_idle_pct = 27;
      rx_idle_pct = 77;
      test_random(80);
      write_csr(CSR_MODE, 16'd0);
      write_csr(CSR_PERIOD, 16'd65535);
      tx_idle_pct = 77;
      rx_idle_pct = 27;
      test_random(70);
      write_csr(CSR_MODE, 16'd1);
      write_csr(CSR_PERIOD, 16'd1);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random(60);
      test_backpressure();
      park();
      if (pending_cmds.size() != 0) mismatches++;
      $display("Covered %0d events and %0d results (%0d preempts, %0d rejects)",
               n_events, n_results, n_preempts, n_rejects);
      $display("in both scheduling modes, aging periods 1 to 65535, with stalls on both sides.");
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #3ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
